// ----- hdl/tlbf_pkg.sv -----
package tlbf_pkg;

	localparam int unsigned PAGE_W  = 20;
	localparam int unsigned FRAME_W = 20;
	localparam int unsigned CNT_W   = 32;

	typedef enum logic [1:0] {
		ACT_LOOKUP   = 2'd0,
		ACT_INSERT   = 2'd1,
		ACT_INV_PAGE = 2'd2,
		ACT_INV_ALL  = 2'd3
	} action_t;

	// request transfer payload
	typedef struct packed {
		action_t              action;
		logic [PAGE_W-1:0]    page_in;
		logic [FRAME_W-1:0]   frame_in;
	} req_t;

	// response transfer payload
	typedef struct packed {
		logic                 hit;
		logic [FRAME_W-1:0]   frame_out;
		logic [CNT_W-1:0]     lookup_count;
		logic [CNT_W-1:0]     hit_count;
		logic [CNT_W-1:0]     miss_count;
		logic [CNT_W-1:0]     insert_count;
	} rsp_t;

	// command broadcast to every cell, with the chain-wide summaries
	typedef struct packed {
		logic                 en;
		action_t              action;
		logic [PAGE_W-1:0]    page;
		logic [FRAME_W-1:0]   frame;
		logic                 full;
		logic                 any_match_all;
		logic                 any_hole_all;
	} cmd_t;

	// carried from each cell to the next one up
	typedef struct packed {
		logic                 any_match;
		logic                 any_hole;
		logic [FRAME_W-1:0]   frame;
	} link_t;

endpackage

// ----- hdl/tlbf_cell.sv -----
module tlbf_cell
	import tlbf_pkg::*;
#(
	parameter int unsigned ENTRIES = 16,
	parameter int unsigned INDEX   = 0,
	localparam int unsigned PTR_W  = $clog2(ENTRIES)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	input  logic [PTR_W-1:0] ptr,
	input  link_t            link_in,
	output link_t            link_out,
	output logic             valid
);

	localparam logic [PTR_W-1:0] IDX = PTR_W'(INDEX);

	logic               valid_q;
	logic [PAGE_W-1:0]  page_q;
	logic [FRAME_W-1:0] frame_q;

	logic eq, match, eligible, hole;
	logic is_insert, upd, fill, fifo_wr;

	// local compare and hole check
	always_comb begin
		eq       = (page_q == cmd.page);
		match    = valid_q && eq;
		eligible = cmd.full || (IDX < ptr);
		hole     = !valid_q && eligible;
	end

	// pass the chain on: lowest match/hole claims, highest match frame wins
	always_comb begin
		link_out.any_match = link_in.any_match | match;
		link_out.any_hole  = link_in.any_hole | hole;
		link_out.frame     = match ? frame_q : link_in.frame;
	end

	// write decisions for this entry
	always_comb begin
		is_insert = cmd.en && (cmd.action == ACT_INSERT);
		upd       = is_insert && match && !link_in.any_match;
		fill      = is_insert && !cmd.any_match_all && hole && !link_in.any_hole;
		fifo_wr   = is_insert && !cmd.any_match_all && !cmd.any_hole_all && (IDX == ptr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.en) begin
			if (cmd.action == ACT_INV_ALL) begin
				valid_q <= 1'b0;
			end else if (cmd.action == ACT_INV_PAGE && eq) begin
				valid_q <= 1'b0;
			end else if (fill || fifo_wr) begin
				valid_q <= 1'b1;
			end
		end
	end

	// tag and data, no reset
	always_ff @(posedge clk) begin
		if (fill || fifo_wr) begin
			page_q <= cmd.page;
		end
		if (upd || fill || fifo_wr) begin
			frame_q <= cmd.frame;
		end
	end

	assign valid = valid_q;

endmodule

// ----- hdl/fully_associative_tlb_fifo.sv -----
// A request sits in the command stage until the output register takes its response.
// Throughput: one request per cycle while responses are taken; the limit is the
//   combinational compare and priority chain running through all ENTRIES cells.
// Reset (arst_n, asynchronous): clears valid bits, FIFO pointer, replacement mode
//   and the four counters at once; tags and frames are left as they are.
module fully_associative_tlb_fifo
	import tlbf_pkg::*;
#(
	parameter int unsigned ENTRIES = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int unsigned PTR_W = $clog2(ENTRIES);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(ENTRIES - 1);

	logic             cmd_valid_q;
	req_t             cmd_q;
	logic [PTR_W-1:0] ptr_q;
	logic             full_q;
	logic [CNT_W-1:0] lookups_q, hits_q, misses_q, inserts_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic             accept, finish;
	cmd_t             cmd;
	link_t            link [ENTRIES+1];
	logic [ENTRIES-1:0] entry_valid;
	logic             is_lookup, is_insert, hit, fifo_wr;

	// handshake: command stage frees when its response goes to the output register
	assign finish    = cmd_valid_q && (!rsp_valid_q || !rsp_stall);
	assign req_stall = cmd_valid_q && !finish;
	assign accept    = req_valid && !req_stall;

	// broadcast to the cells
	always_comb begin
		cmd.en            = finish;
		cmd.action        = cmd_q.action;
		cmd.page          = cmd_q.page_in;
		cmd.frame         = cmd_q.frame_in;
		cmd.full          = full_q;
		cmd.any_match_all = link[ENTRIES].any_match;
		cmd.any_hole_all  = link[ENTRIES].any_hole;
	end

	assign link[0] = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		tlbf_cell #(
			.ENTRIES (ENTRIES),
			.INDEX   (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.ptr      (ptr_q),
			.link_in  (link[i]),
			.link_out (link[i+1]),
			.valid    (entry_valid[i])
		);
	end

	always_comb begin
		is_lookup = (cmd_q.action == ACT_LOOKUP);
		is_insert = (cmd_q.action == ACT_INSERT);
		hit       = is_lookup && link[ENTRIES].any_match;
		fifo_wr   = is_insert && !link[ENTRIES].any_match && !link[ENTRIES].any_hole;
	end

	// command stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
		end else begin
			cmd_valid_q <= accept || (cmd_valid_q && !finish);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req;
		end
	end

	// FIFO pointer, replacement mode and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			full_q    <= 1'b0;
			lookups_q <= '0;
			hits_q    <= '0;
			misses_q  <= '0;
			inserts_q <= '0;
		end else if (finish) begin
			if (fifo_wr) begin
				if (ptr_q == PTR_LAST) begin
					ptr_q  <= '0;
					full_q <= 1'b1;
				end else begin
					ptr_q <= ptr_q + PTR_W'(1);
				end
			end
			lookups_q <= lookups_q + CNT_W'(is_lookup);
			hits_q    <= hits_q + CNT_W'(hit);
			misses_q  <= misses_q + CNT_W'(is_lookup && !hit);
			inserts_q <= inserts_q + CNT_W'(is_insert);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= finish || (rsp_valid_q && rsp_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			rsp_q.hit          <= hit;
			rsp_q.frame_out    <= hit ? link[ENTRIES].frame : '0;
			rsp_q.lookup_count <= lookups_q + CNT_W'(is_lookup);
			rsp_q.hit_count    <= hits_q + CNT_W'(hit);
			rsp_q.miss_count   <= misses_q + CNT_W'(is_lookup && !hit);
			rsp_q.insert_count <= inserts_q + CNT_W'(is_insert);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= PTR_LAST) else $error("FIFO pointer out of range");

	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |=> full_q) else $error("replacement mode dropped");

	a_insert_valid: assert property (@(posedge clk) disable iff (!arst_n)
		finish && is_insert |=> (|entry_valid)) else $error("insert left no valid entry");

	a_inv_all: assert property (@(posedge clk) disable iff (!arst_n)
		finish && (cmd_q.action == ACT_INV_ALL) |=> (entry_valid == '0))
		else $error("invalidate all left a valid entry");

	a_hit_lookup_only: assert property (@(posedge clk) disable iff (!arst_n)
		finish && !is_lookup |=> !rsp_q.hit) else $error("hit on a non-lookup");

endmodule
